// File: hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the status frame receiver
// Wire format constants, register indexes, event codes and the result record.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int PAYLOAD_DEPTH = 16;
  localparam int PAY_ADDR_W    = $clog2(PAYLOAD_DEPTH);
  localparam int PAY_IDX_W     = $clog2(PAYLOAD_DEPTH + 1);

  localparam logic [7:0] SOF_BYTE         = 8'hAA;
  localparam logic [7:0] STATUS_MIN_BYTES = 8'd13;

  localparam logic [4:0] MAX_LEN_RESET    = 5'd16;
  localparam logic [7:0] STATUS_CMD_RESET = 8'h82;
  localparam logic [4:0] STATUS_LEN_RESET = 5'd13;

  localparam int OUT_DATA_W = 152;
  localparam int OUT_USER_W = 3;

  typedef enum logic [1:0] {
    REG_MAX_LEN    = 2'd0,
    REG_STATUS_CMD = 2'd1,
    REG_STATUS_LEN = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_STATUS_OK   = 3'd0,
    EV_CSUM_ERR    = 3'd1,
    EV_LEN_LONG    = 3'd2,
    EV_STATUS_LEN  = 3'd3,
    EV_OTHER_CMD   = 3'd4
  } event_t;

  typedef enum logic [4:0] {
    PH_WAIT = 5'b00001,
    PH_CMD  = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_PAY  = 5'b01000,
    PH_CHK  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [31:0] good_frame_count;
    logic [7:0]  status_flags;
    logic [15:0] right_vel;
    logic [15:0] left_vel;
    logic [31:0] right_odom;
    logic [31:0] left_odom;
    logic [7:0]  frame_len;
    logic [7:0]  frame_cmd;
    event_t      event_res;
  } result_t;

endpackage

// File: hw/rtl/status_frame_receiver.sv
// ----------------------------------------------------------------------------
// status_frame_receiver: deframer for start/command/length/payload/checksum
// Parses one received byte per cycle while in_tready is high and reports each finished or aborted frame.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one received serial byte per transaction in in_tdata[7:0].
//   out_* : one transaction per finished or aborted frame. out_tuser carries
//           the event code, out_tdata the frame command, length, decoded
//           status fields and the good frame count.
//   cfg_* : register writes (0 max payload length, 1 status command,
//           2 status length); always ready, apply to the next byte.
//   A byte is taken every cycle while in_tready is high; the frame state
//   updates in that same cycle and the result for a checksum or over-length
//   byte is registered into the output register, or the skid register when busy.
//   A two-entry result buffer (output register plus skid register) lets bytes
//   keep flowing while a result waits; in_tready drops only when both hold
//   results that the receiver has not yet taken.
//   Reset returns the parser to waiting for a start byte, clears the frame
//   counter, empties the result buffer and loads the register defaults.
//   The payload store is not cleared.
// ----------------------------------------------------------------------------
module status_frame_receiver (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] frame_cmd, [15:8] frame_len, [47:16] left odometer,
  // [79:48] right odometer, [95:80] left speed, [111:96] right speed,
  // [119:112] status_flags, [151:120] good_frame_count
  output logic [sfr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [sfr_pkg::OUT_USER_W-1:0] out_tuser,  // [2:0] event_res
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  logic [4:0]  max_len_r;
  logic [7:0]  status_cmd_r;
  logic [4:0]  status_len_r;

  sfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  held_cmd_r, held_cmd_nxt;
  logic [7:0]  held_len_r, held_len_nxt;
  logic [sfr_pkg::PAY_IDX_W-1:0] pay_idx_r, pay_idx_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [31:0] frame_cnt_r, frame_cnt_nxt;
  logic [7:0]  store_r [sfr_pkg::PAYLOAD_DEPTH];

  sfr_pkg::result_t res;
  logic        res_valid;
  sfr_pkg::result_t out_r, skid_r;
  logic        out_valid_r, skid_valid_r;

  logic        in_acc, pop, push;
  logic [7:0]  b;
  logic [7:0]  limit;
  logic [7:0]  sum_add;
  logic [7:0]  pay_idx_inc;
  logic        store_wr;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign sum_add   = sum_r + b;
  assign pay_idx_inc = 8'(pay_idx_r) + 8'd1;
  assign store_wr  = in_acc && (phase_r == sfr_pkg::PH_PAY) &&
                     (pay_idx_r < sfr_pkg::PAY_IDX_W'(sfr_pkg::PAYLOAD_DEPTH));

  always_comb begin
    if (8'(max_len_r) > 8'(sfr_pkg::PAYLOAD_DEPTH)) begin
      limit = 8'(sfr_pkg::PAYLOAD_DEPTH);
    end else begin
      limit = 8'(max_len_r);
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    held_cmd_nxt  = held_cmd_r;
    held_len_nxt  = held_len_r;
    pay_idx_nxt   = pay_idx_r;
    sum_nxt       = sum_r;
    frame_cnt_nxt = frame_cnt_r;
    res_valid     = 1'b0;
    res           = '0;
    res.event_res = sfr_pkg::EV_STATUS_OK;
    res.frame_cmd = held_cmd_r;
    res.frame_len = held_len_r;
    case (phase_r)
      sfr_pkg::PH_WAIT: begin
        if (b == sfr_pkg::SOF_BYTE) begin
          phase_nxt    = sfr_pkg::PH_CMD;
          held_len_nxt = '0;
          pay_idx_nxt  = '0;
          sum_nxt      = '0;
        end
      end
      sfr_pkg::PH_CMD: begin
        held_cmd_nxt = b;
        sum_nxt      = b;
        phase_nxt    = sfr_pkg::PH_LEN;
      end
      sfr_pkg::PH_LEN: begin
        held_len_nxt = b;
        sum_nxt      = sum_add;
        if (b > limit) begin
          res_valid     = 1'b1;
          res.event_res = sfr_pkg::EV_LEN_LONG;
          res.frame_len = b;
          phase_nxt     = (b == sfr_pkg::SOF_BYTE) ? sfr_pkg::PH_CMD : sfr_pkg::PH_WAIT;
          held_cmd_nxt  = '0;
          held_len_nxt  = '0;
          pay_idx_nxt   = '0;
          sum_nxt       = '0;
        end else if (b == 8'd0) begin
          phase_nxt = sfr_pkg::PH_CHK;
        end else begin
          pay_idx_nxt = '0;
          phase_nxt   = sfr_pkg::PH_PAY;
        end
      end
      sfr_pkg::PH_PAY: begin
        pay_idx_nxt = sfr_pkg::PAY_IDX_W'(pay_idx_inc);
        sum_nxt     = sum_add;
        if (pay_idx_inc >= held_len_r) begin
          phase_nxt = sfr_pkg::PH_CHK;
        end
      end
      sfr_pkg::PH_CHK: begin
        res_valid = 1'b1;
        if (b != sum_r) begin
          res.event_res = sfr_pkg::EV_CSUM_ERR;
        end else if (held_cmd_r == status_cmd_r) begin
          if (held_len_r == 8'(status_len_r)) begin
            res.event_res = sfr_pkg::EV_STATUS_OK;
          end else begin
            res.event_res = sfr_pkg::EV_STATUS_LEN;
          end
        end else begin
          res.event_res = sfr_pkg::EV_OTHER_CMD;
        end
        if (res.event_res == sfr_pkg::EV_STATUS_OK) begin
          res.left_odom    = {store_r[3], store_r[2], store_r[1], store_r[0]};
          res.right_odom   = {store_r[7], store_r[6], store_r[5], store_r[4]};
          res.left_vel     = {store_r[9], store_r[8]};
          res.right_vel    = {store_r[11], store_r[10]};
          res.status_flags = store_r[sfr_pkg::PAY_ADDR_W'(sfr_pkg::STATUS_MIN_BYTES - 8'd1)];
          frame_cnt_nxt    = frame_cnt_r + 32'd1;
        end
        phase_nxt    = (b == sfr_pkg::SOF_BYTE) ? sfr_pkg::PH_CMD : sfr_pkg::PH_WAIT;
        held_cmd_nxt = '0;
        held_len_nxt = '0;
        pay_idx_nxt  = '0;
        sum_nxt      = '0;
      end
      default: begin
        phase_nxt    = sfr_pkg::PH_WAIT;
        held_cmd_nxt = '0;
        held_len_nxt = '0;
        pay_idx_nxt  = '0;
        sum_nxt      = '0;
      end
    endcase
    res.good_frame_count = frame_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= sfr_pkg::MAX_LEN_RESET;
      status_cmd_r <= sfr_pkg::STATUS_CMD_RESET;
      status_len_r <= sfr_pkg::STATUS_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfr_pkg::REG_MAX_LEN:    max_len_r    <= cfg_data[4:0];
        sfr_pkg::REG_STATUS_CMD: status_cmd_r <= cfg_data;
        sfr_pkg::REG_STATUS_LEN: status_len_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sfr_pkg::PH_WAIT;
      held_cmd_r  <= '0;
      held_len_r  <= '0;
      pay_idx_r   <= '0;
      sum_r       <= '0;
      frame_cnt_r <= '0;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      held_cmd_r  <= held_cmd_nxt;
      held_len_r  <= held_len_nxt;
      pay_idx_r   <= pay_idx_nxt;
      sum_r       <= sum_nxt;
      frame_cnt_r <= frame_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_r[pay_idx_r[sfr_pkg::PAY_ADDR_W-1:0]] <= b;
    end
  end

  // two-entry result buffer
  assign pop  = out_valid_r && out_tready;
  assign push = in_acc && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r  <= skid_r;
        skid_r <= res;
      end else begin
        out_r  <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.event_res;
  assign out_tdata  = {out_r.good_frame_count, out_r.status_flags, out_r.right_vel,
                       out_r.left_vel, out_r.right_odom, out_r.left_odom,
                       out_r.frame_len, out_r.frame_cmd};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(frame_cnt_r))
    else $error("frame counter moved without a byte");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.event_res == sfr_pkg::EV_STATUS_OK) |=>
      frame_cnt_r == $past(frame_cnt_r) + 32'd1)
    else $error("good frame did not advance the counter");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.event_res != sfr_pkg::EV_STATUS_OK) |->
      (out_r.left_odom == '0 && out_r.right_odom == '0 && out_r.status_flags == '0))
    else $error("status fields set on a failed frame");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !pop) |=> skid_valid_r && $stable(skid_r))
    else $error("buffered result dropped");

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for status_frame_receiver
// Streams received bytes through the deframer under random sender gaps and
// receiver stalls, predicts every frame report from its own parser model and
// compares each report field by field. Register settings change between
// phases, only while the block is drained.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 12;
  localparam int PHASE_BYTES = 95;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_EXTREME} fill_t;
  typedef enum int {CS_GOOD, CS_BAD, CS_SOF} csum_t;

  typedef struct {
    sfr_pkg::event_t    ev;
    logic [7:0]         cmd;
    logic [7:0]         len;
    logic signed [31:0] odo_l;
    logic signed [31:0] odo_r;
    logic signed [15:0] spd_l;
    logic signed [15:0] spd_r;
    logic [7:0]         flags;
    logic [31:0]        count;
  } frame_report_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata = 8'd0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [sfr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [sfr_pkg::OUT_USER_W-1:0] out_tuser;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [1:0]                     cfg_index = 2'd0;
  logic [7:0]                     cfg_data = 8'd0;

  // predicted parser state and register copy
  sfr_pkg::phase_t rx_phase = sfr_pkg::PH_WAIT;
  logic [7:0]  cur_cmd = 8'd0;
  logic [7:0]  cur_len = 8'd0;
  int          pay_idx = 0;
  logic [7:0]  run_sum = 8'd0;
  logic [7:0]  pay_mem [sfr_pkg::PAYLOAD_DEPTH];
  logic [31:0] good_frames = 32'd0;
  logic [4:0]  lim_max = sfr_pkg::MAX_LEN_RESET;
  logic [7:0]  status_cmd = sfr_pkg::STATUS_CMD_RESET;
  logic [4:0]  status_len = sfr_pkg::STATUS_LEN_RESET;

  logic [7:0]    pending_bytes [$];
  frame_report_t awaited_reports [$];

  int    burst_max = 1;
  int    gap_max = 0;
  int    burst_left = 1;
  int    gap_left = 0;
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [3:0]  stall_pos = 4'd0;

  int cycles = 0;
  int mismatches = 0;
  int bytes_taken = 0;
  int reports_seen = 0;
  int status_ok_seen = 0;
  int settings_used = 1;

  status_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void start_frame();
    rx_phase = sfr_pkg::PH_CMD;
    cur_len  = 8'd0;
    pay_idx  = 0;
    run_sum  = 8'd0;
  endfunction

  function automatic void drop_frame();
    rx_phase = sfr_pkg::PH_WAIT;
    cur_cmd  = 8'd0;
    cur_len  = 8'd0;
    pay_idx  = 0;
    run_sum  = 8'd0;
  endfunction

  function automatic int payload_limit();
    return (lim_max > sfr_pkg::PAYLOAD_DEPTH) ? sfr_pkg::PAYLOAD_DEPTH : int'(lim_max);
  endfunction

  // returns 1 when the byte finishes or aborts a frame
  function automatic bit parse_rx_byte(input logic [7:0] b, output frame_report_t rep);
    bit done;
    rep = '{sfr_pkg::EV_STATUS_OK, 8'd0, 8'd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 8'd0, 32'd0};
    done = 1'b0;
    case (rx_phase)
      sfr_pkg::PH_WAIT: begin
        if (b == sfr_pkg::SOF_BYTE) start_frame();
      end
      sfr_pkg::PH_CMD: begin
        cur_cmd  = b;
        run_sum  = b;
        rx_phase = sfr_pkg::PH_LEN;
      end
      sfr_pkg::PH_LEN: begin
        cur_len = b;
        run_sum = run_sum + b;
        if (b > payload_limit()) begin
          rep.ev    = sfr_pkg::EV_LEN_LONG;
          rep.cmd   = cur_cmd;
          rep.len   = b;
          rep.count = good_frames;
          done      = 1'b1;
          drop_frame();
          if (b == sfr_pkg::SOF_BYTE) start_frame();
        end else if (b == 8'd0) begin
          rx_phase = sfr_pkg::PH_CHK;
        end else begin
          pay_idx  = 0;
          rx_phase = sfr_pkg::PH_PAY;
        end
      end
      sfr_pkg::PH_PAY: begin
        if (pay_idx < sfr_pkg::PAYLOAD_DEPTH) pay_mem[pay_idx] = b;
        pay_idx++;
        run_sum = run_sum + b;
        if (pay_idx >= cur_len) rx_phase = sfr_pkg::PH_CHK;
      end
      sfr_pkg::PH_CHK: begin
        if (b != run_sum) rep.ev = sfr_pkg::EV_CSUM_ERR;
        else if (cur_cmd == status_cmd)
          rep.ev = (cur_len == {3'd0, status_len}) ? sfr_pkg::EV_STATUS_OK :
                                                     sfr_pkg::EV_STATUS_LEN;
        else rep.ev = sfr_pkg::EV_OTHER_CMD;
        rep.cmd = cur_cmd;
        rep.len = cur_len;
        if (rep.ev == sfr_pkg::EV_STATUS_OK) begin
          rep.odo_l = {pay_mem[3], pay_mem[2], pay_mem[1], pay_mem[0]};
          rep.odo_r = {pay_mem[7], pay_mem[6], pay_mem[5], pay_mem[4]};
          rep.spd_l = {pay_mem[9], pay_mem[8]};
          rep.spd_r = {pay_mem[11], pay_mem[10]};
          rep.flags = pay_mem[12];
          good_frames = good_frames + 32'd1;
        end
        rep.count = good_frames;
        done      = 1'b1;
        drop_frame();
        if (b == sfr_pkg::SOF_BYTE) start_frame();
      end
      default: drop_frame();
    endcase
    return done;
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, seen);
    end
  endfunction

  // byte driver: bursts with random gaps
  always @(posedge clk) begin
    frame_report_t rep;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        bytes_taken++;
        if (parse_rx_byte(in_tdata, rep)) awaited_reports.push_back(rep);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || pending_bytes.size() == 0) begin
          in_tvalid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_bytes.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end
        end
      end
    end
  end

  // report monitor with its own stall pattern
  always @(posedge clk) begin
    frame_report_t exp_rep;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        reports_seen++;
        if (awaited_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t: unexpected report, expected none, actual event %h tdata %h",
                     $time, out_tuser, out_tdata);
        end else begin
          exp_rep = awaited_reports.pop_front();
          if (exp_rep.ev == sfr_pkg::EV_STATUS_OK) status_ok_seen++;
          check_field("event_res", {29'd0, exp_rep.ev}, {29'd0, out_tuser[2:0]});
          check_field("frame_cmd", {24'd0, exp_rep.cmd}, {24'd0, out_tdata[7:0]});
          check_field("frame_len", {24'd0, exp_rep.len}, {24'd0, out_tdata[15:8]});
          check_field("left odometer", exp_rep.odo_l, out_tdata[47:16]);
          check_field("right odometer", exp_rep.odo_r, out_tdata[79:48]);
          check_field("left speed", {16'd0, exp_rep.spd_l}, {16'd0, out_tdata[95:80]});
          check_field("right speed", {16'd0, exp_rep.spd_r}, {16'd0, out_tdata[111:96]});
          check_field("status_flags", {24'd0, exp_rep.flags}, {24'd0, out_tdata[119:112]});
          check_field("good_frame_count", exp_rep.count, out_tdata[151:120]);
        end
      end
      out_tready <= stall_pattern[stall_pos];
      stall_pos  <= stall_pos + 4'd1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d reports still awaited", $time, awaited_reports.size());
      $display("[status_frame_receiver] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input sfr_pkg::reg_idx_t idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sfr_pkg::REG_MAX_LEN:    lim_max = val[4:0];
      sfr_pkg::REG_STATUS_CMD: status_cmd = val;
      sfr_pkg::REG_STATUS_LEN: status_len = val[4:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_frames();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_tvalid || awaited_reports.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // keep < 0 sends the whole frame, otherwise it is cut after keep bytes
  task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] len, input fill_t fill,
                             input csum_t csum, input bit with_sof, input int keep,
                             output int n_bytes);
    logic [7:0] frame_q [$];
    logic [7:0] sum;
    logic [7:0] pb;
    logic [7:0] bump;
    int i;
    if (with_sof) frame_q.push_back(sfr_pkg::SOF_BYTE);
    frame_q.push_back(cmd);
    frame_q.push_back(len);
    sum = cmd + len;
    if (len <= payload_limit()) begin
      for (i = 0; i < len; i++) begin
        case (fill)
          FILL_ZERO: pb = 8'h00;
          FILL_ONES: pb = 8'hFF;
          FILL_EXTREME: begin
            case (i)
              3, 9:      pb = 8'h80;
              4, 5, 6, 10: pb = 8'hFF;
              7, 11:     pb = 8'h7F;
              12:        pb = 8'h01;
              default:   pb = 8'h00;
            endcase
          end
          default: pb = 8'($urandom_range(0, 255));
        endcase
        if (csum == CS_SOF && i == len - 1) pb = sfr_pkg::SOF_BYTE - sum;
        frame_q.push_back(pb);
        sum = sum + pb;
      end
      bump = 8'($urandom_range(1, 255));
      frame_q.push_back((csum == CS_BAD) ? sum + bump : sum);
    end
    if (keep >= 0)
      while (frame_q.size() > keep) void'(frame_q.pop_back());
    n_bytes = frame_q.size();
    foreach (frame_q[k]) pending_bytes.push_back(frame_q[k]);
  endtask

  task automatic queue_random_frame(output int n_bytes);
    logic [7:0] cmd;
    logic [7:0] len;
    fill_t fill;
    csum_t csum;
    int r;
    int lim;
    int keep;
    int noise;
    lim = payload_limit();
    r = $urandom_range(0, 99);
    if (r < 55) cmd = status_cmd;
    else if (r < 60) cmd = sfr_pkg::SOF_BYTE;
    else cmd = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 10)
      len = ($urandom_range(0, 2) == 0) ? sfr_pkg::SOF_BYTE :
                                          8'($urandom_range(lim + 1, 255));
    else if (cmd == status_cmd && r < 70) len = {3'd0, status_len};
    else len = 8'($urandom_range(0, lim));
    r = $urandom_range(0, 99);
    if (r < 5) fill = FILL_ZERO;
    else if (r < 10) fill = FILL_ONES;
    else if (r < 15) fill = FILL_EXTREME;
    else fill = FILL_RANDOM;
    r = $urandom_range(0, 99);
    if (r < 80) csum = CS_GOOD;
    else if (r < 90) csum = CS_BAD;
    else csum = CS_SOF;
    keep = ($urandom_range(0, 99) < 6) ? $urandom_range(1, 6) : -1;
    queue_frame(cmd, len, fill, csum, 1'b1, keep, n_bytes);
    if ($urandom_range(0, 9) == 0) begin
      noise = $urandom_range(1, 4);
      repeat (noise) pending_bytes.push_back(8'($urandom_range(0, 255)));
      n_bytes += noise;
    end
  endtask

  initial begin
    int ph;
    int n;
    int phase_bytes;
    logic [4:0] new_max;
    logic [7:0] new_cmd;
    logic [4:0] new_len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: decoded extremes, over-length with restart on the
    // length byte, restart on the checksum byte, zero-length status frame
    queue_frame(sfr_pkg::STATUS_CMD_RESET, 8'd13, FILL_EXTREME, CS_GOOD, 1'b1, -1, n);
    queue_frame(8'h05, sfr_pkg::SOF_BYTE, FILL_RANDOM, CS_GOOD, 1'b1, -1, n);
    queue_frame(8'h05, 8'd1, FILL_RANDOM, CS_SOF, 1'b0, -1, n);
    queue_frame(sfr_pkg::STATUS_CMD_RESET, 8'd0, FILL_RANDOM, CS_GOOD, 1'b0, -1, n);
    drain_frames();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin new_max = 5'd16; new_cmd = 8'h00; new_len = 5'd16; end
        1: begin new_max = 5'd0;  new_cmd = 8'hFF; new_len = 5'd0;  end
        2: begin new_max = 5'd8;  new_cmd = 8'h82; new_len = 5'd13; end  // unreachable
        3: begin  // short status
          new_max = 5'd16; new_cmd = sfr_pkg::SOF_BYTE; new_len = 5'd5;
        end
        4: begin new_max = 5'd13; new_cmd = 8'($urandom_range(0, 255)); new_len = 5'd13; end
        5: begin new_max = 5'd16; new_cmd = 8'h82; new_len = 5'd13; end
        default: begin
          new_max = 5'($urandom_range(0, 16));
          new_cmd = ($urandom_range(0, 9) < 4) ? 8'h82 : 8'($urandom_range(0, 255));
          new_len = 5'($urandom_range(0, 16));
        end
      endcase
      write_reg(sfr_pkg::REG_MAX_LEN, {3'($urandom_range(0, 7)), new_max});
      write_reg(sfr_pkg::REG_STATUS_CMD, new_cmd);
      write_reg(sfr_pkg::REG_STATUS_LEN, {3'($urandom_range(0, 7)), new_len});
      if (ph == 1) write_reg(sfr_pkg::REG_UNUSED, 8'($urandom_range(0, 255)));
      settings_used++;

      case (ph % 3)
        0: begin burst_max = 1; gap_max = 0; stall_pattern = 16'hFFFF; end
        1: begin
          burst_max     = $urandom_range(1, 8);
          gap_max       = $urandom_range(1, 5);
          stall_pattern = 16'($urandom) | 16'h0001;
        end
        default: begin
          burst_max     = $urandom_range(4, 20);
          gap_max       = $urandom_range(1, 3);
          stall_pattern = 16'($urandom | $urandom) | 16'h0001;
        end
      endcase

      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        queue_random_frame(n);
        phase_bytes += n;
      end
      drain_frames();
    end

    $display("covered %0d bytes in %0d register settings: %0d frame reports, %0d decoded",
             bytes_taken, settings_used, reports_seen, status_ok_seen);
    $display("status frames, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("[status_frame_receiver] OK");
    end else begin
      $display("[status_frame_receiver] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sfr_pkg.sv
hw/rtl/status_frame_receiver.sv
tb/sv/testbench.sv
